@@ rtl/bbwr_pkg.sv @@
// Package for the byte buffer with waiting readers.
// Holds default sizes, result kind codes and controller/datapath link types.
// No dependencies.
`default_nettype none
package bbwr_pkg;

  localparam int WAIT_DEPTH_DEF = 8;
  localparam int RING_DEPTH_DEF = 256;
  localparam int ID_BITS_DEF    = 8;

  localparam int ID_W   = 8;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVER = 2'd0,
    KIND_REFUSE  = 2'd1,
    KIND_ACK     = 2'd2
  } kind_t;

  typedef enum logic {
    ACT_READ = 1'b0,
    ACT_BYTE = 1'b1
  } action_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // decide, update pointers, present first result
    logic ack;    // present the sender acknowledge
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_result;   // exec phase produces a result
    logic two_results;  // an acknowledge follows the first result
  } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/bbwr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bbwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/bbwr_ctrl.sv @@
// Controller state machine for the byte buffer with waiting readers.
// Depends on bbwr_pkg.
`default_nettype none
module bbwr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire bbwr_pkg::dp_sts_t sts,
  output bbwr_pkg::dp_cmd_t      cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import bbwr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_ACK  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = sts.two_results ? ST_ACK : ST_IDLE;
      ST_ACK:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cmd.load  = (state_r == ST_IDLE) && start;
  assign cmd.exec  = (state_r == ST_EXEC);
  assign cmd.ack   = (state_r == ST_ACK);
  assign out_valid = (cmd.exec && sts.has_result) || cmd.ack;

endmodule
`default_nettype wire

@@ rtl/bbwr_dp.sv @@
// Datapath: item register, reader queue and byte ring with their pointers.
// Depends on bbwr_pkg and bbwr_ram.
`default_nettype none
module bbwr_dp #(
  parameter int WAIT_DEPTH = bbwr_pkg::WAIT_DEPTH_DEF,
  parameter int RING_DEPTH = bbwr_pkg::RING_DEPTH_DEF,
  parameter int ID_BITS    = bbwr_pkg::ID_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bbwr_pkg::dp_cmd_t           cmd,
  output bbwr_pkg::dp_sts_t                sts,
  input  wire logic                        in_action,
  input  wire logic [bbwr_pkg::ID_W-1:0]   in_requester_id,
  input  wire logic [bbwr_pkg::BYTE_W-1:0] in_byte_value,
  output logic      [bbwr_pkg::KIND_W-1:0] out_kind,
  output logic      [bbwr_pkg::ID_W-1:0]   out_target_id,
  output logic      [bbwr_pkg::BYTE_W-1:0] out_delivered_byte,
  output logic                             out_last
);
  import bbwr_pkg::*;

  localparam int IDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int RAW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RCW = $clog2(RING_DEPTH + 1);
  localparam logic [WCW:0] WDEP = (WCW+1)'(WAIT_DEPTH);
  localparam logic [RCW:0] RDEP = (RCW+1)'(RING_DEPTH);

  // captured item
  logic             act_r;
  logic [IDW-1:0]   id_r;
  logic [BYTE_W-1:0] val_r;

  // queue and ring pointers
  logic [WAW-1:0] w_head_r, w_head_nxt;
  logic [WCW-1:0] w_cnt_r,  w_cnt_nxt;
  logic [RAW-1:0] r_head_r, r_head_nxt;
  logic [RCW-1:0] r_cnt_r,  r_cnt_nxt;

  logic [IDW-1:0]    w_rdata;
  logic [BYTE_W-1:0] r_rdata;
  logic [WAW-1:0]    w_tail, w_head_inc;
  logic [RAW-1:0]    r_tail, r_head_inc;
  logic [WCW:0]      w_sum;
  logic [RCW:0]      r_sum;
  logic              w_nonempty, w_full, r_nonempty, r_full;
  logic              w_push, w_pop, r_push, r_pop;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      id_r  <= in_requester_id[IDW-1:0];
      val_r <= in_byte_value;
    end
  end

  assign w_nonempty = (w_cnt_r != '0);
  assign w_full     = ((WCW+1)'(w_cnt_r) == WDEP);
  assign r_nonempty = (r_cnt_r != '0);
  assign r_full     = ((RCW+1)'(r_cnt_r) == RDEP);

  // tail = head + count, wrapped once
  assign w_sum  = (WCW+1)'(w_head_r) + (WCW+1)'(w_cnt_r);
  assign w_tail = WAW'((w_sum >= WDEP) ? (w_sum - WDEP) : w_sum);
  assign r_sum  = (RCW+1)'(r_head_r) + (RCW+1)'(r_cnt_r);
  assign r_tail = RAW'((r_sum >= RDEP) ? (r_sum - RDEP) : r_sum);

  assign w_head_inc = ((WCW+1)'(w_head_r) + 1'b1 == WDEP) ? '0 : w_head_r + 1'b1;
  assign r_head_inc = ((RCW+1)'(r_head_r) + 1'b1 == RDEP) ? '0 : r_head_r + 1'b1;

  // decisions in the exec phase
  assign r_pop  = cmd.exec && (act_r == ACT_READ) && r_nonempty;
  assign w_push = cmd.exec && (act_r == ACT_READ) && !r_nonempty && !w_full;
  assign w_pop  = cmd.exec && (act_r == ACT_BYTE) && w_nonempty;
  assign r_push = cmd.exec && (act_r == ACT_BYTE) && !w_nonempty && !r_full;

  assign sts.two_results = (act_r == ACT_BYTE) && w_nonempty;
  assign sts.has_result  = !((act_r == ACT_READ) && !r_nonempty && !w_full);

  always_comb begin
    w_head_nxt = w_head_r;
    w_cnt_nxt  = w_cnt_r;
    r_head_nxt = r_head_r;
    r_cnt_nxt  = r_cnt_r;
    if (w_pop) begin
      w_head_nxt = w_head_inc;
      w_cnt_nxt  = w_cnt_r - 1'b1;
    end
    if (w_push) begin
      w_cnt_nxt = w_cnt_r + 1'b1;
    end
    if (r_pop) begin
      r_head_nxt = r_head_inc;
      r_cnt_nxt  = r_cnt_r - 1'b1;
    end
    if (r_push) begin
      r_cnt_nxt = r_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_head_r <= '0;
      w_cnt_r  <= '0;
      r_head_r <= '0;
      r_cnt_r  <= '0;
    end else begin
      w_head_r <= w_head_nxt;
      w_cnt_r  <= w_cnt_nxt;
      r_head_r <= r_head_nxt;
      r_cnt_r  <= r_cnt_nxt;
    end
  end

  // both stores read at their head continuously; data valid the cycle after load
  bbwr_ram #(.WIDTH(IDW), .DEPTH(WAIT_DEPTH), .AW(WAW)) u_wait_ram (
    .clk   (clk),
    .we    (w_push),
    .waddr (w_tail),
    .wdata (id_r),
    .raddr (w_head_r),
    .rdata (w_rdata)
  );

  bbwr_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH), .AW(RAW)) u_ring_ram (
    .clk   (clk),
    .we    (r_push),
    .waddr (r_tail),
    .wdata (val_r),
    .raddr (r_head_r),
    .rdata (r_rdata)
  );

  always_comb begin
    out_kind           = KIND_ACK;
    out_target_id      = ID_W'(id_r);
    out_delivered_byte = '0;
    out_last           = 1'b1;
    if (cmd.exec) begin
      if (act_r == ACT_READ) begin
        if (r_nonempty) begin
          out_kind           = KIND_DELIVER;
          out_delivered_byte = r_rdata;
        end else begin
          out_kind = KIND_REFUSE;
        end
      end else if (w_nonempty) begin
        out_kind           = KIND_DELIVER;
        out_target_id      = ID_W'(w_rdata);
        out_delivered_byte = val_r;
        out_last           = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/byte_buffer_with_waiting_readers.sv @@
// Byte buffer with waiting readers: top level.
// Results: the first result comes in the cycle after the accepting edge; the sender
//   acknowledge after a delivery to a waiting reader comes in the cycle after that.
// Items: a new item is taken only while idle: capture, then an exec step behind the
//   registered RAM read, then an ack step when a byte meets a waiting reader.
// Reset: synchronous rst_n empties queue and ring; results cannot be stalled.
`default_nettype none
module byte_buffer_with_waiting_readers #(
  parameter int WAIT_DEPTH = bbwr_pkg::WAIT_DEPTH_DEF,
  parameter int RING_DEPTH = bbwr_pkg::RING_DEPTH_DEF,
  parameter int ID_BITS    = bbwr_pkg::ID_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input beat: taken when start is high and busy is low
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_action,
  input  wire logic [bbwr_pkg::ID_W-1:0]   in_requester_id,
  input  wire logic [bbwr_pkg::BYTE_W-1:0] in_byte_value,
  // result beat: each result is shown for a single cycle, marked by out_valid
  output logic                             out_valid,
  output logic      [bbwr_pkg::KIND_W-1:0] out_kind,
  output logic      [bbwr_pkg::ID_W-1:0]   out_target_id,
  output logic      [bbwr_pkg::BYTE_W-1:0] out_delivered_byte,
  output logic                             out_last
);
  import bbwr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence: the controller captures the item, then in the exec cycle the
  // datapath pops, or pushes unless full, the reader queue or byte ring and
  // shows the first result if there is one; a byte that serves a waiting reader adds an ack cycle.
  bbwr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bbwr_dp #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .RING_DEPTH (RING_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_requester_id    (in_requester_id),
    .in_byte_value      (in_byte_value),
    .out_kind           (out_kind),
    .out_target_id      (out_target_id),
    .out_delivered_byte (out_delivered_byte),
    .out_last           (out_last)
  );

  // An accepted beat always holds the block busy for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // Results only appear while an item is in work.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  // A delivery that is not last is followed by the sender acknowledge.
  a_ack_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> (out_valid && out_last && out_kind == KIND_ACK))
    else $error("missing acknowledge after delivery to waiting reader");

  // Acknowledges and refusals always carry a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_ACK || out_kind == KIND_REFUSE))
      |-> (out_delivered_byte == '0))
    else $error("nonzero byte on ack or refuse");

endmodule
`default_nettype wire
